[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLKD(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

[rtl/hsd_pkg.sv]
// ----------------------------------------------------------------------------
// hsd_pkg
// Types, constants and round functions of the HChaCha20 subkey pipeline.
// ----------------------------------------------------------------------------
package hsd_pkg;

    // Field widths
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned FIELD_W    = 64;
    localparam int unsigned CFG_IDX_W  = 2;

    // Ten double rounds, each cut into four half quarter-round steps
    localparam int unsigned TOTAL_DOUBLE_ROUNDS = 10;
    localparam int unsigned STEPS_PER_DR        = 4;
    localparam int unsigned NUM_STAGES          = TOTAL_DOUBLE_ROUNDS * STEPS_PER_DR;

    // "expand 32-byte k"
    localparam logic [WORD_W-1:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320_646e;
    localparam logic [WORD_W-1:0] SIGMA_2 = 32'h7962_2d32;
    localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6b20_6574;

    typedef logic [15:0][WORD_W-1:0] state_t;
    typedef logic [7:0][WORD_W-1:0]  key_words_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_A = 2'd0,
        CFG_KEY_B = 2'd1,
        CFG_KEY_C = 2'd2,
        CFG_KEY_D = 2'd3
    } cfg_idx_t;

    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v,
                                                 input logic [4:0] n);
        rotl32 = WORD_W'(v << n) | WORD_W'(v >> (6'd32 - {1'b0, n}));
    endfunction

    // Apply one half of a quarter round to all four quarters of a round.
    // diag selects the diagonal round, second selects the 8/7 rotate half.
    function automatic state_t half_step(input state_t x, input logic diag,
                                         input logic second);
        state_t          y;
        logic [1:0]      qb;
        logic [1:0]      qc;
        logic [1:0]      qd;
        logic [3:0]      ia;
        logic [3:0]      ib;
        logic [3:0]      ic;
        logic [3:0]      id;
        logic [4:0]      r1;
        logic [4:0]      r2;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
        y  = x;
        r1 = second ? 5'd8 : 5'd16;
        r2 = second ? 5'd7 : 5'd12;
        for (int q = 0; q < 4; q++) begin
            qb = 2'(q) + (diag ? 2'd1 : 2'd0);
            qc = 2'(q) + (diag ? 2'd2 : 2'd0);
            qd = 2'(q) + (diag ? 2'd3 : 2'd0);
            ia = {2'b00, 2'(q)};
            ib = {2'b01, qb};
            ic = {2'b10, qc};
            id = {2'b11, qd};
            a = x[ia] + x[ib];
            d = rotl32(x[id] ^ a, r1);
            c = x[ic] + d;
            b = rotl32(x[ib] ^ c, r2);
            y[ia] = a;
            y[ib] = b;
            y[ic] = c;
            y[id] = d;
        end
        half_step = y;
    endfunction

endpackage

[rtl/hsd_if.sv]
// ----------------------------------------------------------------------------
// hsd_if
// Valid/ready channels for nonce words in and subkey words out.
// ----------------------------------------------------------------------------
interface hsd_nonce_if;
    logic        valid;
    logic        ready;
    logic [63:0] nonce_low;
    logic [63:0] nonce_high;

    modport source (output valid, output nonce_low, output nonce_high, input ready);
    modport sink   (input valid, input nonce_low, input nonce_high, output ready);
endinterface

interface hsd_subkey_if;
    logic        valid;
    logic        ready;
    logic [63:0] subkey_a;
    logic [63:0] subkey_b;
    logic [63:0] subkey_c;
    logic [63:0] subkey_d;

    modport source (output valid, output subkey_a, output subkey_b,
                    output subkey_c, output subkey_d, input ready);
    modport sink   (input valid, input subkey_a, input subkey_b,
                    input subkey_c, input subkey_d, output ready);
endinterface

[rtl/hsd_key_regs.sv]
// ----------------------------------------------------------------------------
// hsd_key_regs
// Key configuration registers, presented as state words 4 to 11.
// ----------------------------------------------------------------------------
module hsd_key_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [hsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hsd_pkg::FIELD_W-1:0]    cfg_data,
    output hsd_pkg::key_words_t            key_words
);
    import hsd_pkg::*;

    logic [3:0][FIELD_W-1:0] key_reg;
    logic [3:0][FIELD_W-1:0] key_next;

    // Decode the register index
    always_comb
    begin
        key_next = key_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_KEY_A: key_next[0] = cfg_data;
                CFG_KEY_B: key_next[1] = cfg_data;
                CFG_KEY_C: key_next[2] = cfg_data;
                CFG_KEY_D: key_next[3] = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    // Split each 64-bit register into its low and high state word
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            key_words[2*k]   = key_reg[k][WORD_W-1:0];
            key_words[2*k+1] = key_reg[k][FIELD_W-1:WORD_W];
        end
    end

endmodule

[rtl/hsd_stage.sv]
// ----------------------------------------------------------------------------
// hsd_stage
// One pipeline stage: half a quarter round on all four quarters, registered.
// ----------------------------------------------------------------------------
module hsd_stage #(
    parameter int unsigned STEP = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  hsd_pkg::state_t in_state,
    output logic            out_valid,
    input  logic            out_ready,
    output hsd_pkg::state_t out_state
);
    import hsd_pkg::*;

    // Bit 1 picks column or diagonal round, bit 0 the rotate pair
    localparam logic DIAG   = STEP[1];
    localparam logic SECOND = STEP[0];

    logic   valid_reg;
    logic   valid_next;
    state_t state_reg;
    state_t state_next;

    // Take a word when this stage is empty or its word moves on
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;
    assign state_next = half_step(in_state, DIAG, SECOND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load payload only on an accepted word
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            state_reg <= state_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;

endmodule

[rtl/hchacha20_subkey_derive_top.sv]
// ----------------------------------------------------------------------------
// hchacha20_subkey_derive_top
// HChaCha20 subkey derivation: key in registers, one nonce word per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Write the 256-bit key through cfg_we / cfg_index / cfg_data (index 0 to 3,
//   64 bits each, little-endian) while no word is in flight.
//   Each word on the nonce channel (valid/ready) brings a 128-bit nonce; the
//   subkey channel returns one 256-bit subkey word per nonce, in order.
//   One register stage per half quarter-round step (four stages per double
//   round, ten rounds) lies between nonce acceptance and subkey valid.
//   Throughput: one nonce per cycle when not stalled; up to 40 words in flight.
//   Each stage has its own valid bit and stalls only while full and blocked,
//   so a stalled receiver fills empty stages before nonce.ready drops, and a
//   held subkey word stays stable until taken.
//   Reset clears every valid bit and all key registers to zero.
// ----------------------------------------------------------------------------
module hchacha20_subkey_derive_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [hsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hsd_pkg::FIELD_W-1:0]    cfg_data,
    hsd_nonce_if.sink                      nonce,
    hsd_subkey_if.source                   subkey
);
    import hsd_pkg::*;

    key_words_t key_words;
    state_t     init_state;
    logic       valid_chain [NUM_STAGES+1];
    logic       ready_chain [NUM_STAGES+1];
    state_t     state_chain [NUM_STAGES+1];

    hsd_key_regs u_key_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key_words (key_words)
    );

    // Build the initial state: constants, key, nonce
    always_comb
    begin
        init_state[0]  = SIGMA_0;
        init_state[1]  = SIGMA_1;
        init_state[2]  = SIGMA_2;
        init_state[3]  = SIGMA_3;
        for (int k = 0; k < 8; k++)
        begin
            init_state[4+k] = key_words[k];
        end
        init_state[12] = nonce.nonce_low[WORD_W-1:0];
        init_state[13] = nonce.nonce_low[FIELD_W-1:WORD_W];
        init_state[14] = nonce.nonce_high[WORD_W-1:0];
        init_state[15] = nonce.nonce_high[FIELD_W-1:WORD_W];
    end

    assign valid_chain[0] = nonce.valid;
    assign state_chain[0] = init_state;
    assign nonce.ready    = ready_chain[0];

    // Round pipeline
    for (genvar s = 0; s < NUM_STAGES; s++)
    begin : g_stage
        hsd_stage #(
            .STEP (s % STEPS_PER_DR)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_chain[s]),
            .in_ready  (ready_chain[s]),
            .in_state  (state_chain[s]),
            .out_valid (valid_chain[s+1]),
            .out_ready (ready_chain[s+1]),
            .out_state (state_chain[s+1])
        );
    end

    // Last stage register is the output register
    assign ready_chain[NUM_STAGES] = subkey.ready;
    assign subkey.valid    = valid_chain[NUM_STAGES];
    assign subkey.subkey_a = {state_chain[NUM_STAGES][1],  state_chain[NUM_STAGES][0]};
    assign subkey.subkey_b = {state_chain[NUM_STAGES][3],  state_chain[NUM_STAGES][2]};
    assign subkey.subkey_c = {state_chain[NUM_STAGES][13], state_chain[NUM_STAGES][12]};
    assign subkey.subkey_d = {state_chain[NUM_STAGES][15], state_chain[NUM_STAGES][14]};

endmodule

[rtl/hsd_checker.sv]
// ----------------------------------------------------------------------------
// hsd_checker
// Port-level checks on the subkey pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] subkey_a,
    input logic [63:0] subkey_b,
    input logic [63:0] subkey_c,
    input logic [63:0] subkey_d
);
    import hsd_pkg::*;

    logic       in_acc;
    logic       out_acc;
    logic [6:0] flight_reg;
    logic [6:0] flight_next;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Track words accepted but not yet delivered
    always_comb
    begin
        flight_next = flight_reg;
        if (in_acc && !out_acc)
        begin
            flight_next = flight_reg + 7'd1;
        end
        else if (!in_acc && out_acc)
        begin
            flight_next = flight_reg - 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flight_reg <= '0;
        end
        else
        begin
            flight_reg <= flight_next;
        end
    end

    `ASSERT_CLKD(a_out_hold, out_valid && !out_ready |=> out_valid)
    `ASSERT_CLKD(a_out_stable, out_valid && !out_ready |=> $stable({subkey_a, subkey_b, subkey_c, subkey_d}))
    `ASSERT_ALWAYS(a_ready_free, (out_ready || !out_valid) |-> in_ready)
    `ASSERT_CLKD(a_no_extra, (out_valid |-> flight_reg != 7'd0) && flight_reg <= 7'(NUM_STAGES))

endmodule

bind hchacha20_subkey_derive_top hsd_checker u_hsd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (nonce.valid),
    .in_ready  (nonce.ready),
    .out_valid (subkey.valid),
    .out_ready (subkey.ready),
    .subkey_a  (subkey.subkey_a),
    .subkey_b  (subkey.subkey_b),
    .subkey_c  (subkey.subkey_c),
    .subkey_d  (subkey.subkey_d)
);

[verif/hsd_subkey_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsd_subkey_checker
// Watches the key writes and both channels of the subkey pipeline, works out
// the HChaCha20 subkey of every accepted nonce word from its own copy of the
// key, and compares each returned subkey word field by field, in order.
// ----------------------------------------------------------------------------
module hsd_subkey_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    hsd_nonce_if        nonce_mon,
    hsd_subkey_if       subkey_mon,
    output int          fail_count,
    output int          pending
);
    import hsd_pkg::*;

    typedef logic [15:0][31:0] chacha_state_t;

    typedef struct packed {
        logic [63:0] subkey_a;
        logic [63:0] subkey_b;
        logic [63:0] subkey_c;
        logic [63:0] subkey_d;
    } subkey_t;

    // "expand 32-byte k", word 0 in the low slot
    localparam logic [3:0][31:0] EXPAND_K = {
        32'h6b20_6574, 32'h7962_2d32, 32'h3320_646e, 32'h6170_7865
    };
    localparam int DOUBLE_ROUNDS = 10;

    logic [63:0] key_reg [4];
    subkey_t     expected_subkeys [$];
    int          mismatches = 0;

    assign fail_count = mismatches;

    function automatic logic [31:0] rotate_left32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic chacha_state_t quarter_mix(input chacha_state_t s_in, input int ia,
                                                  input int ib, input int ic, input int id);
        chacha_state_t s;
        logic [31:0]   a;
        logic [31:0]   b;
        logic [31:0]   c;
        logic [31:0]   d;
        s = s_in;
        a = s[ia];
        b = s[ib];
        c = s[ic];
        d = s[id];
        a = a + b; d = rotate_left32(d ^ a, 16);
        c = c + d; b = rotate_left32(b ^ c, 12);
        a = a + b; d = rotate_left32(d ^ a, 8);
        c = c + d; b = rotate_left32(b ^ c, 7);
        s[ia] = a;
        s[ib] = b;
        s[ic] = c;
        s[id] = d;
        return s;
    endfunction

    // Permute constants, key and nonce; keep words 0-3 and 12-15, no add-back
    function automatic subkey_t derive_subkey(input logic [63:0] n_lo, input logic [63:0] n_hi);
        chacha_state_t s;
        subkey_t       r;
        for (int i = 0; i < 4; i++)
        begin
            s[i]         = EXPAND_K[i];
            s[4 + 2 * i] = key_reg[i][31:0];
            s[5 + 2 * i] = key_reg[i][63:32];
        end
        s[12] = n_lo[31:0];
        s[13] = n_lo[63:32];
        s[14] = n_hi[31:0];
        s[15] = n_hi[63:32];
        for (int n = 0; n < DOUBLE_ROUNDS; n++)
        begin
            // column round
            s = quarter_mix(s, 0, 4, 8, 12);
            s = quarter_mix(s, 1, 5, 9, 13);
            s = quarter_mix(s, 2, 6, 10, 14);
            s = quarter_mix(s, 3, 7, 11, 15);
            // diagonal round
            s = quarter_mix(s, 0, 5, 10, 15);
            s = quarter_mix(s, 1, 6, 11, 12);
            s = quarter_mix(s, 2, 7, 8, 13);
            s = quarter_mix(s, 3, 4, 9, 14);
        end
        r.subkey_a = {s[1], s[0]};
        r.subkey_b = {s[3], s[2]};
        r.subkey_c = {s[13], s[12]};
        r.subkey_d = {s[15], s[14]};
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, actual %h", name, want, got);
            mismatches++;
        end
    endtask

    // Retire returned words first, then predict new ones, then take key writes
    always @(posedge clk or negedge rst_n)
    begin
        subkey_t want;
        if (!rst_n)
        begin
            expected_subkeys.delete();
            for (int i = 0; i < 4; i++)
                key_reg[i] = '0;
            pending <= 0;
        end
        else
        begin
            if (subkey_mon.valid && subkey_mon.ready)
            begin
                if (expected_subkeys.size() == 0)
                begin
                    $error("subkey word returned with no nonce outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_subkeys.pop_front();
                    compare_field("subkey_a", want.subkey_a, subkey_mon.subkey_a);
                    compare_field("subkey_b", want.subkey_b, subkey_mon.subkey_b);
                    compare_field("subkey_c", want.subkey_c, subkey_mon.subkey_c);
                    compare_field("subkey_d", want.subkey_d, subkey_mon.subkey_d);
                end
            end
            if (nonce_mon.valid && nonce_mon.ready)
                expected_subkeys.push_back(derive_subkey(nonce_mon.nonce_low,
                                                         nonce_mon.nonce_high));
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_KEY_A: key_reg[0] = cfg_data;
                    CFG_KEY_B: key_reg[1] = cfg_data;
                    CFG_KEY_C: key_reg[2] = cfg_data;
                    CFG_KEY_D: key_reg[3] = cfg_data;
                    default: ;
                endcase
            end
            pending <= expected_subkeys.size();
        end
    end

endmodule

[verif/tb_hchacha20_subkey_derive_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hchacha20_subkey_derive_top
// Drives key writes and nonce words into the HChaCha20 subkey pipeline under
// bursty input and a stalling receiver, and reports the checker's verdict.
// Directed keys and nonces hit the field extremes and the published test
// vector; random phases use fresh keys and mostly random nonces.
// ----------------------------------------------------------------------------
module tb_hchacha20_subkey_derive_top;
    import hsd_pkg::*;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } rx_pattern_t;

    localparam int          RANDOM_PHASES = 5;
    localparam int          PHASE_WORDS   = 380;
    localparam int          LONG_HOLD     = 150;
    localparam int          HOLD_PERIOD   = 1500;
    localparam int          DRAIN_CYCLES  = 60;
    localparam logic [63:0] ALL_ONES      = 64'hffff_ffff_ffff_ffff;
    localparam logic [63:0] ALT_5         = 64'h5555_5555_5555_5555;
    localparam logic [63:0] ALT_A         = 64'haaaa_aaaa_aaaa_aaaa;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        rx_hold;
    int          fail_count;
    int          pending;

    hsd_nonce_if  nonce_ch ();
    hsd_subkey_if subkey_ch ();

    hchacha20_subkey_derive_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .nonce     (nonce_ch),
        .subkey    (subkey_ch)
    );

    hsd_subkey_checker subkey_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .nonce_mon  (nonce_ch),
        .subkey_mon (subkey_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard stop in case the pipeline hangs
    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    // Offer one nonce word and hold it until taken
    task automatic send_nonce(input logic [63:0] lo, input logic [63:0] hi);
        nonce_ch.valid      <= 1'b1;
        nonce_ch.nonce_low  <= lo;
        nonce_ch.nonce_high <= hi;
        do
            @(posedge clk);
        while (!nonce_ch.ready);
    endtask

    task automatic idle_input(input int cycles);
        nonce_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Drop valid and wait until every outstanding subkey word has come back
    task automatic drain_pipeline();
        nonce_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Only called with the pipeline empty
    task automatic load_key(input logic [63:0] ka, input logic [63:0] kb,
                            input logic [63:0] kc, input logic [63:0] kd);
        cfg_idx_t    idx [4];
        logic [63:0] val [4];
        idx = '{CFG_KEY_A, CFG_KEY_B, CFG_KEY_C, CFG_KEY_D};
        val = '{ka, kb, kc, kd};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] random_half();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return 64'd1 << $urandom_range(0, 63);
            3:       return ~(64'd1 << $urandom_range(0, 63));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Bursts of random length with random gaps; keep offering while the
    // receiver holds off, and drain once somewhere in the middle
    task automatic run_random_phase(input int count);
        int sent;
        int burst;
        int gap;
        int pause_at;
        sent     = 0;
        pause_at = $urandom_range(count / 4, 3 * count / 4);
        while (sent < count)
        begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 16);
            for (int n = 0; n < burst && sent < count; n++)
            begin
                send_nonce(random_half(), random_half());
                sent++;
                if (sent == pause_at)
                    drain_pipeline();
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0 && !rx_hold)
                idle_input(gap);
        end
    endtask

    // Receiver: random stall patterns plus a periodic long hold-off
    initial
    begin
        int          cyc;
        int          next_hold;
        int          span;
        rx_pattern_t mode;
        subkey_ch.ready = 1'b0;
        rx_hold         = 1'b0;
        cyc             = 0;
        next_hold       = 300;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (cyc >= next_hold)
            begin
                subkey_ch.ready <= 1'b0;
                rx_hold         <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                cyc       += LONG_HOLD;
                next_hold  = cyc + HOLD_PERIOD;
                rx_hold   <= 1'b0;
            end
            else
            begin
                mode = rx_pattern_t'($urandom_range(0, 3));
                span = $urandom_range(10, 120);
                repeat (span)
                begin
                    case (mode)
                        RX_OPEN:   subkey_ch.ready <= 1'b1;
                        RX_COIN:   subkey_ch.ready <= 1'($urandom_range(0, 1));
                        RX_SPARSE: subkey_ch.ready <= (cyc % 4 == 0);
                        default:   subkey_ch.ready <= ($urandom_range(0, 7) != 0);
                    endcase
                    @(posedge clk);
                    cyc++;
                end
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_KEY_A;
        cfg_data            = '0;
        nonce_ch.valid      = 1'b0;
        nonce_ch.nonce_low  = '0;
        nonce_ch.nonce_high = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Key left at its reset value of zero
        send_nonce('0, '0);
        send_nonce(ALL_ONES, ALL_ONES);
        send_nonce('0, ALL_ONES);
        send_nonce(ALL_ONES, '0);
        drain_pipeline();

        // Published test vector key 00..1f, then nonce extremes
        load_key(64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908,
                 64'h1716_1514_1312_1110, 64'h1f1e_1d1c_1b1a_1918);
        send_nonce(64'h4a00_0000_0900_0000, 64'h2759_4131_0000_0000);
        send_nonce('0, '0);
        send_nonce(ALL_ONES, ALL_ONES);
        send_nonce(64'd1, 64'h8000_0000_0000_0000);
        send_nonce(64'h8000_0000_0000_0000, 64'd1);
        drain_pipeline();

        // All-ones key with extreme and alternating nonces
        load_key(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        send_nonce('0, '0);
        send_nonce(ALL_ONES, ALL_ONES);
        send_nonce(ALL_ONES, '0);
        send_nonce('0, ALL_ONES);
        send_nonce(ALT_5, ALT_A);
        send_nonce(ALT_A, ALT_5);

        // Random phases, one with a mixed extreme key
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain_pipeline();
            if (p == 2)
                load_key('0, ALL_ONES, ALT_5, ALT_A);
            else
                load_key({$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, {$urandom, $urandom});
            run_random_phase(PHASE_WORDS);
        end

        drain_pipeline();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
